[rtl/record_table_with_delete_top_macros.svh]
`ifndef RECORD_TABLE_WITH_DELETE_TOP_MACROS_SVH
`define RECORD_TABLE_WITH_DELETE_TOP_MACROS_SVH

// Plain invariant, sampled on the rising clock edge, off during reset.
`define RTD_ASSERT(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

// Same-cycle implication.
`define RTD_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

[rtl/rtd_pkg.sv]
`default_nettype none

package rtd_pkg;

  localparam int unsigned MAX_ENTRIES_DEF  = 64;
  localparam int unsigned PAYLOAD_BITS_DEF = 64;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PAY_IN_W = 64;
  localparam int unsigned ST_W     = 3;
  localparam int unsigned SLOT_W   = 6;
  localparam int unsigned CNT_W    = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ADD  = 2'd0,
    OP_LDEL = 2'd1,
    OP_PDEL = 2'd2
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_FULL      = 3'd1,
    ST_MARKED    = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_e;

  // Controller to datapath
  typedef struct packed {
    logic    req_load;
    logic    idx_inc;
    logic    rd_en;
    logic    wr_add;
    logic    wr_mark;
    logic    wr_shift;
    logic    cnt_dec;
    logic    slot_load;
    logic    rsp_load;
    status_e rsp_status;
  } rtd_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            full;
    logic            more;
    logic            match;
  } rtd_sts_t;

endpackage

`default_nettype wire

[rtl/rtd_if.sv]
`default_nettype none

interface rtd_req_if;
  import rtd_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            operation;
  logic signed [KEY_W-1:0]    record_key;
  logic [PAY_IN_W-1:0]        record_payload;

  modport source (output valid, output operation, output record_key,
                  output record_payload, input ready);
  modport sink   (input valid, input operation, input record_key,
                  input record_payload, output ready);
endinterface

interface rtd_rsp_if;
  import rtd_pkg::*;

  logic                valid;
  logic                ready;
  logic [ST_W-1:0]     status;
  logic [SLOT_W-1:0]   slot_index;
  logic [CNT_W-1:0]    entry_count;

  modport source (output valid, output status, output slot_index,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input slot_index,
                  input entry_count, output ready);
endinterface

`default_nettype wire

[rtl/rtd_ram.sv]
`default_nettype none

module rtd_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[rtl/rtd_datapath.sv]
`default_nettype none

`include "record_table_with_delete_top_macros.svh"

module rtd_datapath #(
  parameter int unsigned MAX_ENTRIES  = rtd_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned PAYLOAD_BITS = rtd_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rtd_pkg::rtd_cmd_t               cmd_i,
  output rtd_pkg::rtd_sts_t               sts_o,
  input  logic [rtd_pkg::OP_W-1:0]        operation_i,
  input  logic signed [rtd_pkg::KEY_W-1:0] record_key_i,
  input  logic [rtd_pkg::PAY_IN_W-1:0]    record_payload_i,
  output logic [rtd_pkg::ST_W-1:0]        status_o,
  output logic [rtd_pkg::SLOT_W-1:0]      slot_index_o,
  output logic [rtd_pkg::CNT_W-1:0]       entry_count_o
);
  import rtd_pkg::*;

  localparam int unsigned AW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned WW = KEY_W + PAYLOAD_BITS + 1;

  logic [OP_W-1:0]         op_q;
  logic [KEY_W-1:0]        key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [CW-1:0]           count_q, count_d;
  logic [CW-1:0]           idx_q, idx_d;
  logic [CW-1:0]           idx_m1;
  logic [AW-1:0]           slot_q;
  logic [ST_W-1:0]         status_q;
  logic [SLOT_W-1:0]       slot_out_q;
  logic [CNT_W-1:0]        count_out_q;

  logic                    we;
  logic [AW-1:0]           waddr;
  logic [WW-1:0]           wdata;
  logic [WW-1:0]           rdata;
  logic [2:0]              wr_sel;

  // Word layout: {deleted mark, payload, key}
  rtd_ram #(
    .WIDTH  (WW),
    .DEPTH  (MAX_ENTRIES),
    .ADDR_W (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign idx_m1 = idx_q - CW'(1);
  assign wr_sel = {cmd_i.wr_add, cmd_i.wr_mark, cmd_i.wr_shift};

  always_comb begin
    we    = cmd_i.wr_add | cmd_i.wr_mark | cmd_i.wr_shift;
    waddr = idx_q[AW-1:0];
    wdata = rdata;
    if (cmd_i.wr_add) begin
      waddr = count_q[AW-1:0];
      wdata = {1'b0, pay_q, key_q};
    end else if (cmd_i.wr_mark) begin
      wdata = {1'b1, rdata[WW-2:0]};
    end else if (cmd_i.wr_shift) begin
      // move the record one slot down
      waddr = idx_m1[AW-1:0];
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.wr_add) begin
      count_d = count_q + CW'(1);
    end else if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
    idx_d = idx_q;
    if (cmd_i.req_load) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.req_load) begin
      op_q   <= operation_i;
      key_q  <= record_key_i;
      pay_q  <= record_payload_i[PAYLOAD_BITS-1:0];
      slot_q <= '0;
    end else if (cmd_i.wr_add) begin
      slot_q <= count_q[AW-1:0];
    end else if (cmd_i.slot_load) begin
      slot_q <= idx_q[AW-1:0];
    end
    if (cmd_i.rsp_load) begin
      status_q    <= cmd_i.rsp_status;
      slot_out_q  <= SLOT_W'(slot_q);
      count_out_q <= CNT_W'(count_q);
    end
  end

  assign sts_o.op    = op_q;
  assign sts_o.full  = (count_q == CW'(MAX_ENTRIES));
  assign sts_o.more  = (idx_q < count_q);
  assign sts_o.match = (rdata[KEY_W-1:0] == key_q);

  assign status_o      = status_q;
  assign slot_index_o  = slot_out_q;
  assign entry_count_o = count_out_q;

  `RTD_ASSERT(a_count_bound, count_q <= CW'(MAX_ENTRIES), "record count above table depth")
  `RTD_ASSERT_IMPL(a_read_written, cmd_i.rd_en, idx_q < count_q, "read of a slot not yet written")
  `RTD_ASSERT_IMPL(a_add_room, cmd_i.wr_add, count_q < CW'(MAX_ENTRIES), "add into a full table")
  `RTD_ASSERT(a_one_write, $onehot0(wr_sel), "more than one write source in a cycle")
  `RTD_ASSERT_IMPL(a_shift_range, cmd_i.wr_shift, idx_q != '0 && idx_q < count_q, "shift write outside the table")

endmodule

`default_nettype wire

[rtl/rtd_ctrl.sv]
`default_nettype none

module rtd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  input  rtd_pkg::rtd_sts_t sts_i,
  output rtd_pkg::rtd_cmd_t cmd_o
);
  import rtd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEC,
    S_SRD,
    S_SCMP,
    S_MRD,
    S_MWR,
    S_DONE
  } state_e;

  state_e  state_q, state_d;
  status_e result_q, result_d;
  logic    rsp_valid_q, rsp_valid_d;

  always_comb begin
    state_d     = state_q;
    result_d    = result_q;
    rsp_valid_d = rsp_valid_q & ~rsp_ready_i;
    cmd_o       = '0;
    cmd_o.rsp_status = result_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.req_load = 1'b1;
          state_d        = S_DEC;
        end
      end
      S_DEC: begin
        unique case (sts_i.op)
          OP_ADD: begin
            if (sts_i.full) begin
              result_d = ST_FULL;
            end else begin
              cmd_o.wr_add = 1'b1;
              result_d     = ST_ADDED;
            end
            state_d = S_DONE;
          end
          OP_LDEL, OP_PDEL: begin
            state_d = S_SRD;
          end
          default: begin
            result_d = ST_NOT_FOUND;
            state_d  = S_DONE;
          end
        endcase
      end
      S_SRD: begin
        if (sts_i.more) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_SCMP;
        end else begin
          result_d = ST_NOT_FOUND;
          state_d  = S_DONE;
        end
      end
      S_SCMP: begin
        cmd_o.idx_inc = 1'b1;
        if (sts_i.match) begin
          cmd_o.slot_load = 1'b1;
          if (sts_i.op == OP_LDEL) begin
            cmd_o.idx_inc = 1'b0;
            cmd_o.wr_mark = 1'b1;
            result_d      = ST_MARKED;
            state_d       = S_DONE;
          end else begin
            state_d = S_MRD;
          end
        end else begin
          state_d = S_SRD;
        end
      end
      S_MRD: begin
        if (sts_i.more) begin
          cmd_o.rd_en = 1'b1;
          state_d     = S_MWR;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          result_d      = ST_REMOVED;
          state_d       = S_DONE;
        end
      end
      S_MWR: begin
        cmd_o.wr_shift = 1'b1;
        cmd_o.idx_inc  = 1'b1;
        state_d        = S_MRD;
      end
      S_DONE: begin
        // hold until the output register is free
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.rsp_load = 1'b1;
          rsp_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      result_q    <= ST_NOT_FOUND;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      result_q    <= result_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

endmodule

`default_nettype wire

[rtl/record_table_with_delete_top.sv]
`default_nettype none

// Ordered record table with add, logical delete (mark) and physical delete (remove and
// compact), one result beat per request beat. Records live in a single-port-read RAM of
// MAX_ENTRIES words holding key, payload and deleted mark; there is no clearing pass, since
// only slots below the record count are ever read. Requests are handled one at a time. An add
// or an unused operation is decoded and then goes straight to the result. A delete walks the
// table through the RAM's registered read port slot by slot (read, then compare or move),
// visiting at most entry_count slots, hence at most MAX_ENTRIES. A finished result sits in an
// output register, so the next request is taken while it waits.

module record_table_with_delete_top #(
  parameter int unsigned MAX_ENTRIES  = rtd_pkg::MAX_ENTRIES_DEF,
  parameter int unsigned PAYLOAD_BITS = rtd_pkg::PAYLOAD_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  rtd_req_if.sink   req_i,
  rtd_rsp_if.source rsp_o
);
  import rtd_pkg::*;

  rtd_cmd_t cmd;
  rtd_sts_t sts;

  rtd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rtd_datapath #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .operation_i      (req_i.operation),
    .record_key_i     (req_i.record_key),
    .record_payload_i (req_i.record_payload),
    .status_o         (rsp_o.status),
    .slot_index_o     (rsp_o.slot_index),
    .entry_count_o    (rsp_o.entry_count)
  );

endmodule

`default_nettype wire

[tb/tb_record_table_with_delete_top.sv]
`timescale 1ns / 100ps

module tb_record_table_with_delete_top;
  import rtd_pkg::*;

  localparam int unsigned Depth       = MAX_ENTRIES_DEF;
  localparam int unsigned PayloadBits = PAYLOAD_BITS_DEF;
  localparam logic [OP_W-1:0] OpUnused = 2'd3;

  localparam int NumPhases     = 14;
  localparam int PhaseItems    = 125;
  localparam int RspHoldCycles = 400;
  localparam int DrainLatency  = 2 * Depth + 10;
  localparam int MaxReported   = 10;

  typedef struct packed {
    status_e           status;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0]  count;
  } table_rsp_t;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [KEY_W-1:0]    key;
    logic [PAY_IN_W-1:0] payload;
    logic                fixed;
    table_rsp_t          rsp;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  rtd_req_if req_if ();
  rtd_rsp_if rsp_if ();

  record_table_with_delete_top #(
    .MAX_ENTRIES (Depth),
    .PAYLOAD_BITS(PayloadBits)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  // Shadow copy of the table
  logic [KEY_W-1:0]    shadow_key     [Depth];
  logic [PAY_IN_W-1:0] shadow_payload [Depth];
  logic                shadow_mark    [Depth];
  int                  shadow_count;
  int                  peak_count;

  table_rsp_t pending_rsp_q[$];
  int         status_hits[5];
  int         error_cnt;
  int         mismatch_cnt;
  int         rsp_seen;
  bit         quiet_mode;
  bit         rsp_hold_req;

  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic table_rsp_t apply_request(input logic [OP_W-1:0] op,
                                               input logic [KEY_W-1:0] key,
                                               input logic [PAY_IN_W-1:0] payload);
    table_rsp_t r;
    int         hit;
    r.status = ST_NOT_FOUND;
    r.slot   = '0;
    hit      = -1;
    case (op)
      OP_ADD: begin
        if (shadow_count < Depth) begin
          shadow_key[shadow_count]     = key;
          shadow_payload[shadow_count] = payload & ({PAY_IN_W{1'b1}} >> (PAY_IN_W - PayloadBits));
          shadow_mark[shadow_count]    = 1'b0;
          r.slot   = shadow_count[SLOT_W-1:0];
          r.status = ST_ADDED;
          shadow_count++;
        end else begin
          r.status = ST_FULL;
        end
      end
      OP_LDEL, OP_PDEL: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (hit < 0 && shadow_key[i] == key) hit = i;
        end
        if (hit >= 0) begin
          r.slot = hit[SLOT_W-1:0];
          if (op == OP_LDEL) begin
            shadow_mark[hit] = 1'b1;
            r.status = ST_MARKED;
          end else begin
            // compact: pull every later record down one slot
            for (int j = hit; j + 1 < shadow_count; j++) begin
              shadow_key[j]     = shadow_key[j+1];
              shadow_payload[j] = shadow_payload[j+1];
              shadow_mark[j]    = shadow_mark[j+1];
            end
            shadow_count--;
            r.status = ST_REMOVED;
          end
        end
      end
      default: ;
    endcase
    r.count = shadow_count[CNT_W-1:0];
    status_hits[r.status]++;
    if (shadow_count > peak_count) peak_count = shadow_count;
    return r;
  endfunction

  function automatic stim_row_t stim_row(input logic [OP_W-1:0] op,
                                         input logic [KEY_W-1:0] key,
                                         input logic [PAY_IN_W-1:0] payload,
                                         input logic fixed,
                                         input status_e status,
                                         input int slot,
                                         input int count);
    stim_row_t s;
    s.op         = op;
    s.key        = key;
    s.payload    = payload;
    s.fixed      = fixed;
    s.rsp.status = status;
    s.rsp.slot   = slot[SLOT_W-1:0];
    s.rsp.count  = count[CNT_W-1:0];
    return s;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(input bit for_add);
    int r;
    r = $urandom_range(0, 99);
    if (shadow_count > 0 && r < (for_add ? 30 : 60))
      return shadow_key[$urandom_range(0, shadow_count - 1)];
    if (r < 85) begin
      case ($urandom_range(0, 4))
        0:       return 32'h8000_0000;
        1:       return 32'h7fff_ffff;
        2:       return 32'hffff_ffff;
        3:       return 32'h0000_0000;
        default: return $urandom_range(1, 12);
      endcase
    end
    return $urandom;
  endfunction

  task automatic offer_request(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                               input logic [PAY_IN_W-1:0] payload);
    int gap;
    if (!quiet_mode && $urandom_range(0, 99) < 15) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 150) : $urandom_range(1, 3);
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid          <= 1'b1;
    req_if.operation      <= op;
    req_if.record_key     <= key;
    req_if.record_payload <= payload;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_result();
    table_rsp_t want;
    table_rsp_t got;
    got.status = status_e'(rsp_if.status);
    got.slot   = rsp_if.slot_index;
    got.count  = rsp_if.entry_count;
    rsp_seen++;
    if (pending_rsp_q.size() == 0) begin
      error_cnt++;
      $display("[%0t] unexpected result beat: status %0d slot %0d count %0d",
               $realtime, got.status, got.slot, got.count);
    end else begin
      want = pending_rsp_q.pop_front();
      if (got.status !== want.status || got.slot !== want.slot || got.count !== want.count) begin
        error_cnt++;
        mismatch_cnt++;
        if (mismatch_cnt <= MaxReported)
          $display("[%0t] result %0d mismatch: exp status %0d slot %0d count %0d, got %0d %0d %0d",
                   $realtime, rsp_seen, want.status, want.slot, want.count,
                   got.status, got.slot, got.count);
      end
    end
  endtask

  // Result side: random back-pressure, plus one long hold on request
  initial begin : rsp_side
    int hold_left;
    hold_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_if.valid && rsp_if.ready) check_result();
      if (rsp_hold_req) begin
        rsp_hold_req = 1'b0;
        hold_left    = RspHoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (quiet_mode) begin
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  initial begin : stimulus
    stim_row_t          rows[$];
    table_rsp_t         predicted;
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [PAY_IN_W-1:0] payload;
    int                 add_weight[NumPhases];
    int                 real_items;
    int                 r;

    add_weight = '{95, 40, 15, 75, 50, 95, 25, 60, 85, 10, 50, 95, 35, 70};
    error_cnt    = 0;
    mismatch_cnt = 0;
    rsp_seen     = 0;
    shadow_count = 0;
    peak_count   = 0;
    quiet_mode   = 1'b0;
    rsp_hold_req = 1'b0;
    foreach (status_hits[i]) status_hits[i] = 0;

    rst_ni                <= 1'b0;
    req_if.valid          <= 1'b0;
    req_if.operation      <= OP_ADD;
    req_if.record_key     <= '0;
    req_if.record_payload <= '0;

    // empty table, extreme keys and payloads, duplicates, re-marking, unused code
    rows.push_back(stim_row(OP_LDEL, 32'd5, '0, 1'b1, ST_NOT_FOUND, 0, 0));
    rows.push_back(stim_row(OP_PDEL, 32'd5, '0, 1'b1, ST_NOT_FOUND, 0, 0));
    rows.push_back(stim_row(OpUnused, 32'd5, '0, 1'b1, ST_NOT_FOUND, 0, 0));
    rows.push_back(stim_row(OP_ADD, 32'h8000_0000, '1, 1'b1, ST_ADDED, 0, 1));
    rows.push_back(stim_row(OP_ADD, 32'h7fff_ffff, '0, 1'b1, ST_ADDED, 1, 2));
    rows.push_back(stim_row(OP_ADD, 32'h0000_0000, 64'ha5a5_a5a5_a5a5_a5a5, 1'b0,
                            ST_ADDED, 0, 0));
    rows.push_back(stim_row(OP_ADD, 32'h8000_0000, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0,
                            ST_ADDED, 0, 0));
    rows.push_back(stim_row(OP_LDEL, 32'h8000_0000, '1, 1'b1, ST_MARKED, 0, 4));
    rows.push_back(stim_row(OP_LDEL, 32'h8000_0000, '0, 1'b0, ST_MARKED, 0, 0));
    rows.push_back(stim_row(OP_PDEL, 32'h8000_0000, '1, 1'b1, ST_REMOVED, 0, 3));
    rows.push_back(stim_row(OP_PDEL, 32'h8000_0000, '0, 1'b0, ST_REMOVED, 0, 0));
    rows.push_back(stim_row(OP_LDEL, 32'd7, '0, 1'b1, ST_NOT_FOUND, 0, 2));
    rows.push_back(stim_row(OpUnused, 32'hffff_ffff, '1, 1'b1, ST_NOT_FOUND, 0, 2));
    rows.push_back(stim_row(OP_ADD, 32'hffff_ffff, 64'h0123_4567_89ab_cdef, 1'b0,
                            ST_ADDED, 0, 0));
    rows.push_back(stim_row(OP_LDEL, 32'h0000_0000, '0, 1'b0, ST_MARKED, 0, 0));
    rows.push_back(stim_row(OP_PDEL, 32'h0000_0000, '0, 1'b0, ST_REMOVED, 0, 0));
    rows.push_back(stim_row(OP_PDEL, 32'h7fff_ffff, '0, 1'b0, ST_REMOVED, 0, 0));
    rows.push_back(stim_row(OP_PDEL, 32'hffff_ffff, '0, 1'b1, ST_REMOVED, 0, 0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (rows[i]) begin
      offer_request(rows[i].op, rows[i].key, rows[i].payload);
      predicted = apply_request(rows[i].op, rows[i].key, rows[i].payload);
      pending_rsp_q.push_back(rows[i].fixed ? rows[i].rsp : predicted);
    end
    drain_results();

    for (int phase = 0; phase < NumPhases; phase++) begin
      // phase 2 opens with a long result stall so the request side backs up
      if (phase == 2) rsp_hold_req = 1'b1;
      quiet_mode = (phase == 4);
      real_items = 0;
      while (real_items < PhaseItems) begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          op = OpUnused;
        end else if (r < 3 + add_weight[phase] * 97 / 100) begin
          op = OP_ADD;
          real_items++;
        end else begin
          op = $urandom_range(0, 1) ? OP_LDEL : OP_PDEL;
          real_items++;
        end
        key = pick_key(op == OP_ADD);
        case ($urandom_range(0, 9))
          0:       payload = '0;
          1:       payload = '1;
          default: payload = {$urandom, $urandom};
        endcase
        offer_request(op, key, payload);
        pending_rsp_q.push_back(apply_request(op, key, payload));
      end
      drain_results();
    end
    quiet_mode = 1'b0;

    for (int i = 0; i < 50000 && pending_rsp_q.size() != 0; i++) @(posedge clk_i);
    repeat (DrainLatency) @(posedge clk_i);
    if (pending_rsp_q.size() != 0) begin
      error_cnt += pending_rsp_q.size();
      $display("%0d expected results never arrived", pending_rsp_q.size());
    end

    $display("Checked %0d result beats: %0d added, %0d table full, %0d marked, %0d removed,",
             rsp_seen, status_hits[ST_ADDED], status_hits[ST_FULL], status_hits[ST_MARKED],
             status_hits[ST_REMOVED]);
    $display("%0d not found; table fill peaked at %0d of %0d slots, %0d mismatches",
             status_hits[ST_NOT_FOUND], peak_count, Depth, mismatch_cnt);
    if (error_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
